// ----- rtl/histogram_equalization_macros.svh -----
// Assertion macros used by the checker file.
`ifndef HISTOGRAM_EQUALIZATION_MACROS_SVH
`define HISTOGRAM_EQUALIZATION_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define HEQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define HEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/heq_pkg.sv -----
// ---------------------------------------------------------------------------
// Histogram equalization package
// Shared types and constants for the equalizer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package heq_pkg;
  localparam int unsigned LevelsDefault    = 256;
  localparam int unsigned MaxPixelsDefault = 4194304;
  localparam int unsigned CntW             = 29;
  localparam int unsigned QueueDepth       = 4;

  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_MAP   = 1'b1
  } op_e;

  typedef struct packed {
    logic       opcode;
    logic [7:0] pixel;
    logic       frame_last;
  } req_t;

  typedef struct packed {
    logic [7:0] mapped_pixel;
    logic       last_out;
  } rsp_t;

  // Back part phases.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_SUM,
    ST_DIV,
    ST_CLR
  } state_e;
endpackage
`default_nettype wire

// ----- rtl/heq_front.sv -----
// ---------------------------------------------------------------------------
// Histogram equalization front queue
// Accepts requests and buffers them in a small queue ahead of the engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module heq_front (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           push_i,
  input  heq_pkg::req_t req_i,
  output logic          full_o,
  output logic          empty_o,
  input  wire           pop_i,
  output heq_pkg::req_t head_o
);
  localparam int unsigned AW = $clog2(heq_pkg::QueueDepth);

  heq_pkg::req_t     mem_q [heq_pkg::QueueDepth];
  logic [AW-1:0]     wp_q, rp_q;
  logic [AW:0]       cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(heq_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rp_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= req_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/heq_back.sv -----
// ---------------------------------------------------------------------------
// Histogram equalization engine
// Counts pixels, builds the level table with a serial divider, maps pixels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module heq_back #(
  parameter int unsigned LEVELS     = heq_pkg::LevelsDefault,
  parameter int unsigned MAX_PIXELS = heq_pkg::MaxPixelsDefault
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           empty_i,
  input  heq_pkg::req_t head_i,
  output logic          pop_o,
  output logic          strobe_o,
  output heq_pkg::rsp_t rsp_o
);
  localparam int unsigned CW   = heq_pkg::CntW;
  localparam int unsigned IW   = 8;
  // Saturated bins can push cdf past the total, up to LEVELS*MAX_PIXELS, so
  // the numerator 2*L*cdf+total needs up to CW+18 bits.
  localparam int unsigned NW   = CW + 18;
  localparam int unsigned QW   = 9;
  localparam logic [CW-1:0] MaxP = CW'(MAX_PIXELS);
  localparam logic [IW:0]   LastIdx = (IW+1)'(LEVELS - 1);

  logic [CW-1:0] bins_q [256];
  logic [CW-1:0] bins_rd_q;
  logic [7:0]    table_q [256];
  logic [7:0]    table_rd_q;
  logic          built_q;    // table filled by at least one build
  logic [255:0]  bvalid_q;   // bin written since last clear
  logic          bv_rd_q, tv_rd_q, map_oor_q;

  heq_pkg::state_e st_q, st_d;
  heq_pkg::req_t   cur_q;
  logic [CW-1:0]   total_q;
  logic [CW+8:0]   cdf_q;
  logic [IW:0]     idx_q;
  logic [NW-1:0]   rem_q;
  logic [QW-1:0]   quo_q;
  logic [QW-1:0]   quo_d;
  logic [3:0]      step_q;
  logic            acc_pend_q, map_pend_q;
  logic [CW-1:0]   cnt_now;
  logic [NW:0]     trial;

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      heq_pkg::ST_IDLE: if (acc_pend_q && cur_q.frame_last) st_d = heq_pkg::ST_RD;
      heq_pkg::ST_RD:   st_d = heq_pkg::ST_SUM;
      heq_pkg::ST_SUM:  st_d = heq_pkg::ST_DIV;
      heq_pkg::ST_DIV:  if (step_q == 4'd0) st_d = (idx_q == LastIdx) ?
                          heq_pkg::ST_CLR : heq_pkg::ST_RD;
      heq_pkg::ST_CLR:  st_d = heq_pkg::ST_IDLE;
      default:          st_d = heq_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the control.
  always_comb begin
    pop_o = (st_q == heq_pkg::ST_IDLE) && !empty_i && !acc_pend_q && !map_pend_q;
  end

  assign cnt_now = bv_rd_q ? bins_rd_q : '0;
  assign trial   = {1'b0, rem_q} - {1'b0, NW'({total_q, 1'b0}) << step_q};
  // Quotient including the bit decided this cycle.
  assign quo_d   = trial[NW] ? quo_q : (quo_q | (QW'(1) << step_q));

  // Memory ports: bins are read at the head pixel or the walk index.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      bins_rd_q  <= bins_q[head_i.pixel];
      table_rd_q <= table_q[head_i.pixel];
    end else if (st_q == heq_pkg::ST_RD) begin
      bins_rd_q <= bins_q[idx_q[IW-1:0]];
    end
    if (acc_pend_q && ({1'b0, cur_q.pixel} < (IW+1)'(LEVELS))) begin
      bins_q[cur_q.pixel] <= (bv_rd_q && bins_rd_q >= MaxP) ? MaxP :
                             (bv_rd_q ? bins_rd_q : '0) + 1'b1;
    end
    if (st_q == heq_pkg::ST_DIV && step_q == 4'd0) begin
      table_q[idx_q[IW-1:0]] <= (total_q == '0) ? 8'd0 :
                                quo_d[QW-1] ? 8'd255 : quo_d[7:0];
    end
  end

  // Control and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= heq_pkg::ST_IDLE;
      acc_pend_q <= 1'b0;
      map_pend_q <= 1'b0;
      total_q    <= '0;
      cdf_q      <= '0;
      idx_q      <= '0;
      built_q    <= 1'b0;
      bvalid_q   <= '0;
      strobe_o   <= 1'b0;
      rsp_o      <= '0;
      step_q     <= '0;
      rem_q      <= '0;
      quo_q      <= '0;
      cur_q      <= '0;
      bv_rd_q    <= 1'b0;
      tv_rd_q    <= 1'b0;
      map_oor_q  <= 1'b0;
    end else begin
      st_q     <= st_d;
      strobe_o <= map_pend_q;
      if (pop_o) begin
        cur_q      <= head_i;
        acc_pend_q <= (head_i.opcode == heq_pkg::OP_ACCUM);
        map_pend_q <= (head_i.opcode == heq_pkg::OP_MAP);
        bv_rd_q    <= bvalid_q[head_i.pixel];
        tv_rd_q    <= built_q;
        map_oor_q  <= ({1'b0, head_i.pixel} >= (IW+1)'(LEVELS));
      end
      if (map_pend_q) begin
        map_pend_q         <= 1'b0;
        rsp_o.mapped_pixel <= (tv_rd_q && !map_oor_q) ? table_rd_q : 8'd0;
        rsp_o.last_out     <= cur_q.frame_last;
      end
      if (acc_pend_q) begin
        acc_pend_q <= 1'b0;
        if ({1'b0, cur_q.pixel} < (IW+1)'(LEVELS)) begin
          bvalid_q[cur_q.pixel] <= 1'b1;
          if (total_q < MaxP) total_q <= total_q + 1'b1;
        end
        cdf_q <= '0;
        idx_q <= '0;
      end
      case (st_q)
        heq_pkg::ST_RD: begin
          bv_rd_q <= bvalid_q[idx_q[IW-1:0]];
        end
        heq_pkg::ST_SUM: begin
          cdf_q  <= cdf_q + (CW+9)'(cnt_now);
          rem_q  <= (NW'(cdf_q + (CW+9)'(cnt_now)) * NW'(2 * LEVELS)) + NW'(total_q);
          quo_q  <= '0;
          step_q <= 4'(QW - 1);
        end
        heq_pkg::ST_DIV: begin
          // Restoring division, one quotient bit a cycle.
          if (!trial[NW]) begin
            rem_q <= trial[NW-1:0];
          end
          quo_q <= quo_d;
          if (step_q != 4'd0) begin
            step_q <= step_q - 1'b1;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        heq_pkg::ST_CLR: begin
          built_q  <= 1'b1;
          bvalid_q <= '0;
          total_q  <= '0;
          cdf_q    <= '0;
          idx_q    <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/histogram_equalization.sv -----
// ---------------------------------------------------------------------------
// Histogram equalization top level
// Two-pass grey-level equalizer: count a frame, build the table, map pixels.
// ---------------------------------------------------------------------------
// Channel | Signals                  | Handshake
// request | start, req_i, busy       | taken when start and !busy
// result  | done_o, rsp_o            | one-cycle strobe, no back pressure
//
// A map request passes the queue, the engine's pending register and the result
// register before its result appears; an accumulate request blocks the next pop
// while its bin is updated. A frame-last accumulate runs the table build: for
// each of LEVELS bins a read, a sum and a serial division, then a clear state.
// Requests queue (4 deep) and then busy holds.
// Reset clears counts through valid bits, empties the queue and marks the table unbuilt.
`timescale 1ns / 1ps
`default_nettype none
module histogram_equalization #(
  parameter int unsigned LEVELS     = heq_pkg::LevelsDefault,
  parameter int unsigned MAX_PIXELS = heq_pkg::MaxPixelsDefault
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           start,
  input  heq_pkg::req_t req_i,
  output logic          busy,
  output logic          done_o,
  output heq_pkg::rsp_t rsp_o
);
  logic          full, empty, pop;
  heq_pkg::req_t head;

  assign busy = full;

  // Request queue.
  heq_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(start && !busy), .req_i(req_i),
    .full_o(full), .empty_o(empty), .pop_i(pop), .head_o(head)
  );

  // Counting, table build and mapping.
  heq_back #(.LEVELS(LEVELS), .MAX_PIXELS(MAX_PIXELS)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .empty_i(empty), .head_i(head),
    .pop_o(pop), .strobe_o(done_o), .rsp_o(rsp_o)
  );
endmodule
`default_nettype wire

// ----- rtl/heq_checker.sv -----
// ---------------------------------------------------------------------------
// Histogram equalization checker
// Port-level checks on reset and result behavior.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "histogram_equalization_macros.svh"
module heq_checker (
  input wire           clk_i,
  input wire           rst_ni,
  input wire           start,
  input wire           busy,
  input wire           done_o,
  input heq_pkg::rsp_t rsp_o
);
  `HEQ_ASSERT_IMP(a_known_done, clk_i, rst_ni, 1'b1, !$isunknown(done_o))
  `HEQ_ASSERT_NEXT(a_busy_after_reset, clk_i, rst_ni, !$past(rst_ni), !busy)
  `HEQ_ASSERT_IMP(a_rsp_known, clk_i, rst_ni, done_o, !$isunknown(rsp_o))
endmodule
bind histogram_equalization heq_checker u_heq_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .done_o(done_o), .rsp_o(rsp_o)
);
`default_nettype wire
